/* design/teq_pkg.sv */
// ----------------------------------------------------------------------------
// teq_pkg: timed event queue shared definitions
// Operation codes, controller states, cell control/status bundles and sizes.
// ----------------------------------------------------------------------------
package teq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int ID_COUNT_DEF = 256;
	localparam int MAX_FIRE     = 16;
	localparam int POP_W        = $clog2(MAX_FIRE);
	localparam int TIME_W       = 64;
	localparam int ID_W         = 8;
	localparam logic [TIME_W-1:0] ALL_ONES = '1;

	typedef enum logic [2:0] {
		OP_ADVANCE     = 3'd0,
		OP_ADD         = 3'd1,
		OP_RESCHED_REL = 3'd2,
		OP_RESCHED_ABS = 3'd3,
		OP_CANCEL      = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_REPORT,
		ST_POP
	} state_t;

	// per-cell command: ins = ordered insert of the new entry, shl = take right neighbor
	typedef struct packed {
		logic ins;
		logic shl;
	} cell_ctl_t;

	// per-cell status: occupied, due time <= key, id matches key id
	typedef struct packed {
		logic valid;
		logic le;
		logic hit;
	} cell_stat_t;

endpackage

/* design/teq_cell.sv */
// ----------------------------------------------------------------------------
// teq_cell: one slot of the ordered event chain
// Holds one entry (due time, id) and shifts toward or away from the head
// using only its own compare and its neighbors' contents.
// ----------------------------------------------------------------------------
module teq_cell #(
	parameter int IdW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  teq_pkg::cell_ctl_t         ctl,
	input  logic [teq_pkg::TIME_W-1:0] key,
	input  logic [IdW-1:0]             key_id,
	input  logic [teq_pkg::TIME_W-1:0] new_time,
	input  logic [IdW-1:0]             new_id,
	input  logic                       left_valid,
	input  logic                       left_le,
	input  logic [teq_pkg::TIME_W-1:0] left_time,
	input  logic [IdW-1:0]             left_id,
	input  logic                       right_valid,
	input  logic [teq_pkg::TIME_W-1:0] right_time,
	input  logic [IdW-1:0]             right_id,
	output teq_pkg::cell_stat_t        stat,
	output logic [teq_pkg::TIME_W-1:0] entry_time,
	output logic [IdW-1:0]             entry_id
);

	logic                       valid_q;
	logic [teq_pkg::TIME_W-1:0] time_q;
	logic [IdW-1:0]             id_q;
	logic                       le;

	assign le = valid_q && (time_q <= key);

	assign stat.valid = valid_q;
	assign stat.le    = le;
	assign stat.hit   = valid_q && (id_q == key_id);
	assign entry_time = time_q;
	assign entry_id   = id_q;

	// insert lands after every entry with due time <= key, so equal times keep order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (ctl.ins && !le) begin
				valid_q <= left_le ? 1'b1 : left_valid;
			end else if (ctl.shl) begin
				valid_q <= right_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.ins && !le) begin
			if (left_le) begin
				time_q <= new_time;
				id_q   <= new_id;
			end else begin
				time_q <= left_time;
				id_q   <= left_id;
			end
		end else if (ctl.shl) begin
			time_q <= right_time;
			id_q   <= right_id;
		end
	end

endmodule

/* design/timed_event_queue_top.sv */
// Sequence: an advance goes IDLE to POP, which registers one fired event per cycle while
// the output is not held; add goes IDLE, INSERT, REPORT; reschedule IDLE, REMOVE, INSERT,
// REPORT; cancel IDLE, REMOVE, REPORT; unused codes IDLE, REPORT. Input is taken only in
// IDLE, one item at a time; a held result stalls the controller.
// Reset: arst_n clears the current time and empties every cell at once; no clearing pass.
// ----------------------------------------------------------------------------
// timed_event_queue_top: timestamp ordered event queue
// A chain of cells kept sorted by due time, driven by a small controller that
// inserts, removes by id and pops due events from the head.
// ----------------------------------------------------------------------------
module timed_event_queue_top #(
	parameter int CAPACITY = teq_pkg::CAPACITY_DEF,
	parameter int ID_COUNT = teq_pkg::ID_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [71:0]  s_axis_tdata,  // amount[63:0], event_id[71:64]
	input  logic [2:0]   s_axis_tuser,  // operation[2:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [207:0] m_axis_tdata,  // fired_id[7:0], lateness[71:8], due_time[135:72],
	                                    // next_due[199:136], status[200], zero pad
	output logic [0:0]   m_axis_tuser,  // fired[0]
	output logic         m_axis_tlast   // last
);

	localparam int IdW = $clog2(ID_COUNT);
	localparam int TW  = teq_pkg::TIME_W;

	teq_pkg::state_t state_q, state_d;
	teq_pkg::op_t    op_q, op_in;
	logic [IdW-1:0]  id_q;
	logic [TW-1:0]   due_q, now_q;
	logic [teq_pkg::POP_W-1:0] pop_q;
	logic            full_q;

	logic            m_valid_q, fired_q, status_q, last_q;
	logic [teq_pkg::ID_W-1:0] fired_id_q;
	logic [TW-1:0]   late_q, due_out_q, next_q;

	logic            s_accept, s_ready, slot_free;
	logic            emit, pop_en, ins_en, remove_en;
	logic            e_fired, e_status, e_last;
	logic [teq_pkg::ID_W-1:0] e_id;
	logic [TW-1:0]   e_late, e_due, e_next, head_next, second_next, cell_key;

	logic [IdW-1:0]      id_tbl [256];
	teq_pkg::cell_stat_t stat_w [CAPACITY];
	teq_pkg::cell_ctl_t  ctl_w  [CAPACITY];
	logic [TW-1:0]       time_w [CAPACITY];
	logic [IdW-1:0]      id_w   [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;

	// id reduction table, built at elaboration
	for (genvar v = 0; v < 256; v++) begin : g_idtbl
		assign id_tbl[v] = IdW'(v % ID_COUNT);
	end

	assign op_in    = teq_pkg::op_t'(s_axis_tuser);
	assign s_accept = s_axis_tvalid && s_ready;
	assign slot_free = !m_valid_q || m_axis_tready;
	assign s_axis_tready = s_ready;
	assign cell_key  = (state_q == teq_pkg::ST_POP) ? now_q : due_q;
	assign remove_en = (state_q == teq_pkg::ST_REMOVE);

	assign head_next   = stat_w[0].valid ? time_w[0] : teq_pkg::ALL_ONES;
	assign second_next = stat_w[1].valid ? time_w[1] : teq_pkg::ALL_ONES;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                at_or_after;
		logic                later_hit;
		logic                lv, lle, rv;
		logic [TW-1:0]       lt, rt;
		logic [IdW-1:0]      lid, rid;

		assign hit_vec[g]   = stat_w[g].hit;
		assign at_or_after  = |hit_vec[g:0];
		if (g == CAPACITY - 1) begin : g_tail
			assign later_hit = 1'b0;
			assign rv  = 1'b0;
			assign rt  = '0;
			assign rid = '0;
		end else begin : g_mid
			assign later_hit = |hit_vec[CAPACITY-1:g+1];
			assign rv  = stat_w[g+1].valid;
			assign rt  = time_w[g+1];
			assign rid = id_w[g+1];
		end
		if (g == 0) begin : g_head
			assign lv  = 1'b0;
			assign lle = 1'b1;
			assign lt  = '0;
			assign lid = '0;
		end else begin : g_body
			assign lv  = stat_w[g-1].valid;
			assign lle = stat_w[g-1].le;
			assign lt  = time_w[g-1];
			assign lid = id_w[g-1];
		end

		// removal closes the gap at the last matching entry
		assign ctl_w[g].ins = ins_en;
		assign ctl_w[g].shl = pop_en || (remove_en && at_or_after && !later_hit);

		teq_cell #(.IdW(IdW)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl_w[g]),
			.key         (cell_key),
			.key_id      (id_q),
			.new_time    (due_q),
			.new_id      (id_q),
			.left_valid  (lv),
			.left_le     (lle),
			.left_time   (lt),
			.left_id     (lid),
			.right_valid (rv),
			.right_time  (rt),
			.right_id    (rid),
			.stat        (stat_w[g]),
			.entry_time  (time_w[g]),
			.entry_id    (id_w[g])
		);
	end

	// controller outputs
	always_comb begin
		s_ready  = 1'b0;
		emit     = 1'b0;
		pop_en   = 1'b0;
		ins_en   = 1'b0;
		e_fired  = 1'b0;
		e_id     = '0;
		e_late   = '0;
		e_due    = '0;
		e_next   = '0;
		e_status = 1'b0;
		e_last   = 1'b0;
		unique case (state_q)
			teq_pkg::ST_IDLE: begin
				s_ready = 1'b1;
			end
			teq_pkg::ST_REMOVE: begin
				s_ready = 1'b0;
			end
			teq_pkg::ST_INSERT: begin
				ins_en = !stat_w[CAPACITY-1].valid;
			end
			teq_pkg::ST_REPORT: begin
				emit     = slot_free;
				e_due    = due_q;
				e_next   = head_next;
				e_status = full_q;
				e_last   = 1'b1;
			end
			teq_pkg::ST_POP: begin
				emit = slot_free;
				if (stat_w[0].le) begin
					pop_en  = slot_free;
					e_fired = 1'b1;
					e_id    = teq_pkg::ID_W'(id_w[0]);
					e_late  = now_q - time_w[0];
					e_next  = second_next;
					e_last  = (pop_q == teq_pkg::POP_W'(teq_pkg::MAX_FIRE - 1))
						|| !stat_w[1].le;
				end else begin
					e_next = head_next;
					e_last = 1'b1;
				end
			end
			default: begin
				s_ready = 1'b0;
			end
		endcase
	end

	// controller next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			teq_pkg::ST_IDLE: begin
				if (s_accept) begin
					unique case (op_in)
						teq_pkg::OP_ADVANCE:     state_d = teq_pkg::ST_POP;
						teq_pkg::OP_ADD:         state_d = teq_pkg::ST_INSERT;
						teq_pkg::OP_RESCHED_REL: state_d = teq_pkg::ST_REMOVE;
						teq_pkg::OP_RESCHED_ABS: state_d = teq_pkg::ST_REMOVE;
						teq_pkg::OP_CANCEL:      state_d = teq_pkg::ST_REMOVE;
						default:                 state_d = teq_pkg::ST_REPORT;
					endcase
				end
			end
			teq_pkg::ST_REMOVE: begin
				if (op_q == teq_pkg::OP_RESCHED_REL || op_q == teq_pkg::OP_RESCHED_ABS) begin
					state_d = teq_pkg::ST_INSERT;
				end else begin
					state_d = teq_pkg::ST_REPORT;
				end
			end
			teq_pkg::ST_INSERT: begin
				state_d = teq_pkg::ST_REPORT;
			end
			teq_pkg::ST_REPORT: begin
				if (slot_free) state_d = teq_pkg::ST_IDLE;
			end
			teq_pkg::ST_POP: begin
				if (slot_free && e_last) state_d = teq_pkg::ST_IDLE;
			end
			default: begin
				state_d = teq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= teq_pkg::ST_IDLE;
			now_q     <= '0;
			pop_q     <= '0;
			full_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_accept && op_in == teq_pkg::OP_ADVANCE) begin
				now_q <= now_q + s_axis_tdata[63:0];
			end
			priority if (s_accept) begin
				pop_q <= '0;
			end else if (pop_en) begin
				pop_q <= pop_q + teq_pkg::POP_W'(1);
			end
			priority if (s_accept) begin
				full_q <= 1'b0;
			end else if (state_q == teq_pkg::ST_INSERT) begin
				full_q <= stat_w[CAPACITY-1].valid;
			end
			priority if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q <= op_in;
			id_q <= id_tbl[s_axis_tdata[71:64]];
			unique case (op_in)
				teq_pkg::OP_ADD:         due_q <= now_q + s_axis_tdata[63:0];
				teq_pkg::OP_RESCHED_REL: due_q <= now_q + s_axis_tdata[63:0];
				teq_pkg::OP_RESCHED_ABS: due_q <= s_axis_tdata[63:0];
				default:                 due_q <= '0;
			endcase
		end
		if (emit) begin
			fired_q    <= e_fired;
			fired_id_q <= e_id;
			late_q     <= e_late;
			due_out_q  <= e_due;
			next_q     <= e_next;
			status_q   <= e_status;
			last_q     <= e_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, status_q, next_q, due_out_q, late_q, fired_id_q};
	assign m_axis_tuser  = fired_q;
	assign m_axis_tlast  = last_q;

endmodule

/* design/teq_checker.sv */
// ----------------------------------------------------------------------------
// teq_checker: port-level checks for the timed event queue
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module teq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [207:0] m_axis_tdata,
	input logic [0:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	// one item at a time: ready drops right after an input transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in progress");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// a result that reports no fired event ends its run
	a_nofire_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast
		&& m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[71:8] == 64'd0)
		else $error("non-fired result malformed");

	// fired results carry no assigned due time and never a full flag
	a_fire_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[135:72] == 64'd0
		&& !m_axis_tdata[200])
		else $error("fired result carries insert fields");

endmodule

bind timed_event_queue_top teq_checker u_teq_checker (.*);

/* tb/timed_event_queue_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_top_test: self-checking bench for the timed event queue
// A directed opening covers the empty queue, time wrap, equal due times,
// duplicate ids and spare opcodes. Random bursts follow: mixed traffic, fills
// past capacity and wide-valued noise. Every input transfer is run through a
// local model of the sorted queue, and each output transfer is compared field
// by field with the oldest report still awaited.
// ----------------------------------------------------------------------------
module timed_event_queue_top_test;

	localparam int          RANDOM_ITEMS = 405;
	localparam int          LONG_HOLD    = 200;
	localparam int          DRAIN_CYCLES = 20;
	localparam logic [2:0]  OP_SPARE_LO  = 3'(teq_pkg::OP_CANCEL) + 3'd1;
	localparam logic [2:0]  OP_SPARE_HI  = 3'b111;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] amount;
		logic [7:0]  id;
		logic        wait_idle;	// hold this item back until every report is in
	} ev_item_t;

	typedef struct packed {
		logic        fired;
		logic [7:0]  fired_id;
		logic [63:0] lateness;
		logic [63:0] due_time;
		logic [63:0] next_due;
		logic        status;
		logic        last;
	} report_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata = '0;	// amount[63:0], event_id[71:64]
	logic [2:0]   s_axis_tuser = '0;	// operation[2:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [207:0] m_axis_tdata;	// fired_id, lateness, due_time, next_due, status, pad
	logic [0:0]   m_axis_tuser;	// fired
	logic         m_axis_tlast;

	timed_event_queue_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// model of the sorted queue
	logic [63:0] now_time = '0;
	logic [63:0] slot_time [teq_pkg::CAPACITY_DEF];
	logic [7:0]  slot_id   [teq_pkg::CAPACITY_DEF];
	int          slot_count = 0;

	ev_item_t    pending_items[$];
	report_t     upcoming_reports[$];
	logic [63:0] gen_time = '0;	// time the queue will show once queued items are done
	int          directed_items = 0;
	int          rand_items = 0;
	int          items_in = 0;
	int          reports_seen = 0;
	int          fired_total = 0;
	int          full_drops = 0;
	int          long_holds = 0;
	int          mismatches = 0;

	function automatic logic [63:0] head_due();
		return (slot_count != 0) ? slot_time[0] : teq_pkg::ALL_ONES;
	endfunction

	// goes after every entry due at or before t, so equal times keep arrival order
	function automatic bit slot_insert(input logic [63:0] t, input logic [7:0] eid);
		int pos;
		int k;
		if (slot_count >= teq_pkg::CAPACITY_DEF)
			return 1'b0;
		pos = 0;
		while (pos < slot_count && slot_time[pos] <= t)
			pos++;
		for (k = slot_count; k > pos; k--) begin
			slot_time[k] = slot_time[k-1];
			slot_id[k]   = slot_id[k-1];
		end
		slot_time[pos] = t;
		slot_id[pos]   = eid;
		slot_count++;
		return 1'b1;
	endfunction

	function automatic void slot_drop(input int pos);
		int k;
		for (k = pos; k + 1 < slot_count; k++) begin
			slot_time[k] = slot_time[k+1];
			slot_id[k]   = slot_id[k+1];
		end
		slot_count--;
	endfunction

	// drops the entry for eid that would fire last
	function automatic void drop_latest(input logic [7:0] eid);
		int k;
		for (k = slot_count - 1; k >= 0; k--) begin
			if (slot_id[k] == eid) begin
				slot_drop(k);
				return;
			end
		end
	endfunction

	task automatic step_event_queue(input ev_item_t it);
		logic [63:0] due;
		logic [7:0]  eid;
		bit          ok;
		int          n;
		report_t     r;
		eid = 8'(it.id % teq_pkg::ID_COUNT_DEF);
		r = '0;
		r.last = 1'b1;
		case (it.op)
			teq_pkg::OP_ADVANCE: begin
				now_time += it.amount;
				n = 0;
				while (n < teq_pkg::MAX_FIRE && slot_count > 0 && slot_time[0] <= now_time) begin
					r = '0;
					r.fired    = 1'b1;
					r.fired_id = slot_id[0];
					r.lateness = now_time - slot_time[0];
					slot_drop(0);
					r.next_due = head_due();
					r.last     = (n + 1 == teq_pkg::MAX_FIRE) || slot_count == 0 ||
					             slot_time[0] > now_time;
					upcoming_reports = {upcoming_reports, r};
					fired_total++;
					n++;
				end
				if (n == 0) begin
					r.next_due = head_due();
					upcoming_reports = {upcoming_reports, r};
				end
			end
			teq_pkg::OP_ADD, teq_pkg::OP_RESCHED_REL, teq_pkg::OP_RESCHED_ABS: begin
				due = (it.op == teq_pkg::OP_RESCHED_ABS) ? it.amount : now_time + it.amount;
				if (it.op != teq_pkg::OP_ADD)
					drop_latest(eid);
				ok = slot_insert(due, eid);
				if (!ok)
					full_drops++;
				r.due_time = due;
				r.status   = !ok;
				r.next_due = head_due();
				upcoming_reports = {upcoming_reports, r};
			end
			teq_pkg::OP_CANCEL: begin
				drop_latest(eid);
				r.next_due = head_due();
				upcoming_reports = {upcoming_reports, r};
			end
			default: begin
				r.next_due = head_due();
				upcoming_reports = {upcoming_reports, r};
			end
		endcase
	endtask

	// mostly back to back, sometimes a few cycles, rarely a long gap
	function automatic int draw_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_item(input logic [2:0] op, input logic [63:0] amount,
	                         input logic [7:0] eid, input bit wait_idle = 1'b0);
		ev_item_t it;
		it.op        = op;
		it.amount    = amount;
		it.id        = eid;
		it.wait_idle = wait_idle;
		pending_items = {pending_items, it};
		if (op == teq_pkg::OP_ADVANCE)
			gen_time += amount;
	endtask

	// small id pool so reschedules and cancels usually hit something
	function automatic logic [7:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 8'($urandom_range(0, 5));
		if (r < 72)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic logic [63:0] pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 75)
			return 64'($urandom_range(1, 40));
		if (r < 92)
			return 64'($urandom_range(41, 2000));
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return '0;
		if (r < 85)
			return 64'($urandom_range(1, 25));
		if (r < 95)
			return 64'($urandom_range(26, 300));
		return {$urandom, $urandom};
	endfunction

	task automatic random_item(input bit wait_idle);
		int r;
		r = $urandom_range(0, 99);
		if (r < 34)
			push_item(teq_pkg::OP_ADD, pick_delay(), pick_id(), wait_idle);
		else if (r < 56)
			push_item(teq_pkg::OP_ADVANCE, pick_step(), 8'($urandom), wait_idle);
		else if (r < 68)
			push_item(teq_pkg::OP_RESCHED_REL, pick_delay(), pick_id(), wait_idle);
		else if (r < 80)
			push_item(teq_pkg::OP_RESCHED_ABS,
			          ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} :
			          gen_time + 64'($urandom_range(0, 60)), pick_id(), wait_idle);
		else if (r < 94)
			push_item(teq_pkg::OP_CANCEL, {$urandom, $urandom}, pick_id(), wait_idle);
		else
			push_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), {$urandom, $urandom},
			          8'($urandom), wait_idle);
		rand_items++;
	endtask

	// driver
	ev_item_t cur_item;
	int       send_gap = 0;

	always @(posedge clk or negedge arst_n) begin : sender
		logic offer;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			send_gap = 0;
		end else begin
			offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				step_event_queue(cur_item);
				items_in++;
				offer = 1'b0;
				send_gap = ((items_in / 60) % 4 == 3) ? 0 : draw_idle();
			end
			if (!offer) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_items.size() != 0 &&
				         !(pending_items[0].wait_idle && upcoming_reports.size() != 0)) begin
					cur_item = pending_items.pop_front();
					s_axis_tdata <= {cur_item.id, cur_item.amount};
					s_axis_tuser <= cur_item.op;
					offer = 1'b1;
				end
			end
			s_axis_tvalid <= offer;
		end
	end

	// output side ready, with one long hold-off now and then
	int hold_left = 0;
	int reports_taken = 0;
	int next_long_hold = 100;

	always @(posedge clk or negedge arst_n) begin : receiver
		int gap;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				reports_taken++;
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (reports_taken >= next_long_hold) begin
				m_axis_tready <= 1'b0;
				hold_left = LONG_HOLD;
				next_long_hold += 600;
				long_holds++;
			end else begin
				gap = ((reports_taken / 50) % 4 == 1) ? 0 : draw_idle();
				if (gap == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					hold_left = gap - 1;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// monitor
	always @(posedge clk) begin : monitor
		report_t got;
		report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.fired    = m_axis_tuser[0];
			got.fired_id = m_axis_tdata[7:0];
			got.lateness = m_axis_tdata[71:8];
			got.due_time = m_axis_tdata[135:72];
			got.next_due = m_axis_tdata[199:136];
			got.status   = m_axis_tdata[200];
			got.last     = m_axis_tlast;
			reports_seen++;
			if (upcoming_reports.size() == 0) begin
				$error("output transfer with no report awaited: fired %0b id 0x%0h",
				       got.fired, got.fired_id);
				mismatches++;
			end else begin
				want = upcoming_reports.pop_front();
				check_field("fired", 64'(want.fired), 64'(got.fired));
				check_field("fired_id", 64'(want.fired_id), 64'(got.fired_id));
				check_field("lateness", want.lateness, got.lateness);
				check_field("due_time", want.due_time, got.due_time);
				check_field("next_due", want.next_due, got.next_due);
				check_field("status", 64'(want.status), 64'(got.status));
				check_field("last", 64'(want.last), 64'(got.last));
			end
		end
	end

	initial begin : stimulus
		int  kind;
		bit  first;
		// empty queue, absent id, spare opcodes
		push_item(teq_pkg::OP_ADVANCE, '0, 8'h00);
		push_item(teq_pkg::OP_CANCEL, '0, 8'h00);
		push_item(OP_SPARE_LO, teq_pkg::ALL_ONES, 8'hFF);
		push_item(OP_SPARE_HI, '0, 8'h00);
		// due right now, and a delay of all ones that wraps to one time unit before now
		push_item(teq_pkg::OP_ADD, '0, 8'hFF);
		push_item(teq_pkg::OP_ADD, teq_pkg::ALL_ONES, 8'h00);
		push_item(teq_pkg::OP_ADVANCE, '0, 8'h00);
		// equal due times, duplicate ids, reschedule of the later duplicate
		push_item(teq_pkg::OP_ADD, 64'd10, 8'hAA);
		push_item(teq_pkg::OP_ADD, 64'd10, 8'hAA);
		push_item(teq_pkg::OP_ADD, 64'd10, 8'h55);
		push_item(teq_pkg::OP_RESCHED_REL, 64'd5, 8'hAA);
		push_item(teq_pkg::OP_RESCHED_ABS, gen_time + 64'd7, 8'h33);
		push_item(teq_pkg::OP_CANCEL, teq_pkg::ALL_ONES, 8'h55);
		// time wraps to one below, then moves past everything
		push_item(teq_pkg::OP_ADVANCE, teq_pkg::ALL_ONES, 8'hFF);
		push_item(teq_pkg::OP_ADVANCE, 64'd20, 8'h00);
		push_item(teq_pkg::OP_RESCHED_ABS, teq_pkg::ALL_ONES, 8'h7E);
		push_item(teq_pkg::OP_CANCEL, '0, 8'h7E);
		push_item(teq_pkg::OP_ADVANCE, '0, 8'h00, 1'b1);
		directed_items = pending_items.size();

		while (rand_items < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind <= 1) begin
				// run past capacity, then one advance pops a long train
				repeat ($urandom_range(15, 19)) begin
					push_item(teq_pkg::OP_ADD, 64'($urandom_range(1, 80)), pick_id());
					rand_items++;
				end
				push_item(teq_pkg::OP_RESCHED_REL, 64'($urandom_range(0, 50)),
				          8'($urandom_range(128, 255)));
				push_item(teq_pkg::OP_RESCHED_ABS, gen_time + 64'($urandom_range(0, 90)),
				          pick_id());
				push_item(teq_pkg::OP_ADVANCE, 64'($urandom_range(60, 120)), 8'($urandom));
				rand_items += 3;
			end else if (kind == 8) begin
				repeat (12) begin
					push_item(3'($urandom), {$urandom, $urandom}, 8'($urandom));
					rand_items++;
				end
			end else begin
				first = (kind == 9);
				repeat (20) begin
					random_item(first);
					first = 1'b0;
				end
				if (kind == 9) begin
					push_item(teq_pkg::OP_ADVANCE, {$urandom, $urandom}, 8'($urandom));
					push_item(teq_pkg::OP_ADVANCE, '0, 8'($urandom));
					rand_items += 2;
				end
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || s_axis_tvalid || upcoming_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input transfers (%0d directed), %0d results, %0d events fired,",
		         items_in, directed_items, reports_seen, fired_total);
		$display("%0d inserts dropped on a full queue, %0d long output stalls",
		         full_drops, long_holds);
		if (mismatches == 0 && upcoming_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
